// ----- hw/rtl/bawst_pkg.sv -----
// shared widths, codes and state type of the block averaged window stats unit
package bawst_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SUM_W         = 23;
    localparam int BLOCK_LEN_W   = 8;
    localparam int SLOT_COUNT_W  = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam int RING_SLOTS_DEF = 64;
    localparam int MAX_BLOCK_DEF  = 128;

    localparam logic [BLOCK_LEN_W-1:0]  BLOCK_LEN_RST  = 8'd1;
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 7'd10;

    localparam logic [SAMPLE_W-1:0] SAMPLE_ONES = 16'hFFFF;
    localparam logic [SUM_W-1:0]    SUM_ZERO    = 23'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_LEN  = 2'd0,
        CFG_SLOT_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MDIV,
        S_INIT,
        S_SCAN,
        S_MUL,
        S_TOTAL,
        S_TDIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic mean_sel;
    } div_ctrl_t;

endpackage

// ----- hw/rtl/bawst_if.sv -----
// request channels for samples in and window statistics out
interface bawst_in_if;
    import bawst_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface bawst_out_if;
    import bawst_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] window_mean;
    logic [SAMPLE_W-1:0] window_min;
    logic [SAMPLE_W-1:0] window_max;
    logic                ring_full;

    modport source (output valid, output window_mean, output window_min,
                    output window_max, output ring_full, input ready);
    modport sink (input valid, input window_mean, input window_min,
                  input window_max, input ring_full, output ready);
endinterface

// ----- hw/rtl/bawst_ram.sv -----
// generic simple dual port ram with registered read
module bawst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/bawst_div.sv -----
// restoring divider, one quotient bit per cycle
module bawst_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bawst_pkg::div_ctrl_t  ctrl,
    input  logic [NW-1:0]         dividend,
    input  logic [DW-1:0]         divisor,
    output logic                  done,
    output logic [NW-1:0]         quotient
);
    import bawst_pkg::*;

    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        ge    = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/block_averaged_window_stats.sv -----
// top level: block averaged moving mean, minimum and maximum over a slot ring
//
//  channel   dir  contents
//  in_ch     in   sample
//  out_ch    out  window_mean, window_min, window_max, ring_full
//  cfg       in   cfg_we, cfg_index, cfg_data (0 block length, 1 slot_count)
//
// one sample passes through sequencing and the slot ring scan, then through the
// shared bit-serial divider for the window mean (its dividend width NW is 32 at
// default parameters), and once more, before the scan, when it closes a block
// reset or any write to a known register clears the ring pointers and the open block
// a result waits in the output register while the next sample is taken

module block_averaged_window_stats #(
    parameter int RING_SLOTS = bawst_pkg::RING_SLOTS_DEF,
    parameter int MAX_BLOCK  = bawst_pkg::MAX_BLOCK_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bawst_in_if.sink                         in_ch,
    bawst_out_if.source                      out_ch,
    input  logic                             cfg_we,
    input  logic [bawst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bawst_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bawst_pkg::*;

    localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RING_SLOTS + 1);
    localparam int BLK_W  = $clog2(MAX_BLOCK + 1);
    localparam int MSUM_W = SAMPLE_W + CNT_W;
    localparam int PROD_W = MSUM_W + BLK_W;
    localparam int ACC_W  = CNT_W + BLK_W;
    localparam int DIVN_W = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
    localparam int DIVD_W = ACC_W + 1;
    localparam int RAM_W  = 3 * SAMPLE_W;

    // configuration
    logic [BLOCK_LEN_W-1:0]  block_len_reg;
    logic [SLOT_COUNT_W-1:0] slot_count_reg;
    logic                    cfg_hit;
    logic [BLK_W-1:0]        bs_eff;
    logic [CNT_W-1:0]        sc_eff;

    // block and ring state
    logic [SUM_W-1:0]      block_sum_reg;
    logic [SAMPLE_W-1:0]   block_low_reg;
    logic [SAMPLE_W-1:0]   block_high_reg;
    logic [BLK_W-1:0]      block_fill_reg;
    logic [SLOT_W-1:0]     write_slot_reg;
    logic [CNT_W-1:0]      slots_written_reg;

    // scan accumulators
    logic [CNT_W-1:0]      idx_reg;
    logic                  rd_v_reg;
    logic [MSUM_W-1:0]     msum_reg;
    logic [ACC_W-1:0]      cnt_reg;
    logic [SAMPLE_W-1:0]   lo_reg;
    logic [SAMPLE_W-1:0]   hi_reg;
    logic [PROD_W-1:0]     prod_reg;

    // output register
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_mean_reg;
    logic [SAMPLE_W-1:0]   out_min_reg;
    logic [SAMPLE_W-1:0]   out_max_reg;
    logic                  out_full_reg;

    state_t                state_reg;
    state_t                state_next;

    logic                  in_ready;
    logic                  ram_we;
    logic                  ram_re;
    logic                  out_load;
    div_ctrl_t             div_ctrl;
    logic                  div_done;
    logic [DIVN_W-1:0]     div_dividend;
    logic [DIVD_W-1:0]     div_divisor;
    logic [DIVN_W-1:0]     div_quotient;
    logic [RAM_W-1:0]      ram_wdata;
    logic [RAM_W-1:0]      ram_rdata;
    logic [SAMPLE_W-1:0]   rd_mean;
    logic [SAMPLE_W-1:0]   rd_min;
    logic [SAMPLE_W-1:0]   rd_max;
    logic [CNT_W-1:0]      slot_inc;

    assign cfg_hit = cfg_we && (cfg_index == CFG_BLOCK_LEN || cfg_index == CFG_SLOT_COUNT);

    always_comb
    begin
        if (block_len_reg == '0)
        begin
            bs_eff = BLK_W'(1);
        end
        else if (32'(block_len_reg) > 32'(MAX_BLOCK))
        begin
            bs_eff = BLK_W'(MAX_BLOCK);
        end
        else
        begin
            bs_eff = BLK_W'(block_len_reg);
        end

        if (slot_count_reg == '0)
        begin
            sc_eff = CNT_W'(1);
        end
        else if (32'(slot_count_reg) > 32'(RING_SLOTS))
        begin
            sc_eff = CNT_W'(RING_SLOTS);
        end
        else
        begin
            sc_eff = CNT_W'(slot_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg  <= BLOCK_LEN_RST;
            slot_count_reg <= SLOT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_LEN:  block_len_reg  <= cfg_data[BLOCK_LEN_W-1:0];
                CFG_SLOT_COUNT: slot_count_reg <= cfg_data[SLOT_COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (block_fill_reg >= bs_eff) ? S_MDIV : S_INIT;
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg >= slots_written_reg && !rd_v_reg)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready          = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        out_load          = 1'b0;
        div_ctrl.start    = 1'b0;
        div_ctrl.mean_sel = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_CHECK:
            begin
                div_ctrl.start    = block_fill_reg >= bs_eff;
                div_ctrl.mean_sel = 1'b1;
            end
            S_MDIV:
            begin
                ram_we = div_done;
            end
            S_SCAN:
            begin
                ram_re = idx_reg < slots_written_reg;
            end
            S_TOTAL:
            begin
                div_ctrl.start = 1'b1;
            end
            S_OUT:
            begin
                out_load = !out_valid_reg || out_ch.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign slot_inc = CNT_W'(write_slot_reg) + CNT_W'(1);

    // open block and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_sum_reg     <= SUM_ZERO;
            block_low_reg     <= SAMPLE_ONES;
            block_high_reg    <= '0;
            block_fill_reg    <= '0;
            write_slot_reg    <= '0;
            slots_written_reg <= '0;
        end
        else if (cfg_hit)
        begin
            block_sum_reg     <= SUM_ZERO;
            block_low_reg     <= SAMPLE_ONES;
            block_high_reg    <= '0;
            block_fill_reg    <= '0;
            write_slot_reg    <= '0;
            slots_written_reg <= '0;
        end
        else if (in_ch.valid && in_ready)
        begin
            block_sum_reg  <= block_sum_reg + SUM_W'(in_ch.sample);
            block_fill_reg <= block_fill_reg + BLK_W'(1);
            if (in_ch.sample < block_low_reg)
            begin
                block_low_reg <= in_ch.sample;
            end
            if (in_ch.sample > block_high_reg)
            begin
                block_high_reg <= in_ch.sample;
            end
        end
        else if (ram_we)
        begin
            block_sum_reg  <= SUM_ZERO;
            block_low_reg  <= SAMPLE_ONES;
            block_high_reg <= '0;
            block_fill_reg <= '0;
            write_slot_reg <= (slot_inc == sc_eff) ? '0 : slot_inc[SLOT_W-1:0];
            if (slots_written_reg < sc_eff)
            begin
                slots_written_reg <= slots_written_reg + CNT_W'(1);
            end
        end
    end

    assign {rd_mean, rd_min, rd_max} = ram_rdata;

    // slot scan and merge with the open block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (state_reg == S_INIT)
        begin
            rd_v_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            rd_v_reg <= ram_re;
            if (ram_re)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_INIT:
            begin
                msum_reg <= '0;
                cnt_reg  <= '0;
                lo_reg   <= SAMPLE_ONES;
                hi_reg   <= '0;
            end
            S_SCAN:
            begin
                if (rd_v_reg)
                begin
                    msum_reg <= msum_reg + MSUM_W'(rd_mean);
                    cnt_reg  <= cnt_reg + ACC_W'(bs_eff);
                    if (rd_min < lo_reg)
                    begin
                        lo_reg <= rd_min;
                    end
                    if (rd_max > hi_reg)
                    begin
                        hi_reg <= rd_max;
                    end
                end
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(msum_reg) * PROD_W'(bs_eff);
                if (block_low_reg < lo_reg)
                begin
                    lo_reg <= block_low_reg;
                end
                if (block_high_reg > hi_reg)
                begin
                    hi_reg <= block_high_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (div_ctrl.mean_sel)
        begin
            div_dividend = DIVN_W'(block_sum_reg);
            div_divisor  = DIVD_W'(block_fill_reg);
        end
        else
        begin
            div_dividend = DIVN_W'(prod_reg) + DIVN_W'(block_sum_reg);
            div_divisor  = DIVD_W'(cnt_reg) + DIVD_W'(block_fill_reg);
        end
    end

    bawst_div #(
        .NW (DIVN_W),
        .DW (DIVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign ram_wdata = {div_quotient[SAMPLE_W-1:0], block_low_reg, block_high_reg};

    bawst_ram #(
        .WIDTH  (RAM_W),
        .DEPTH  (RING_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_slot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mean_reg <= div_quotient[SAMPLE_W-1:0];
            out_min_reg  <= lo_reg;
            out_max_reg  <= hi_reg;
            out_full_reg <= slots_written_reg >= sc_eff;
        end
    end

    assign in_ch.ready        = in_ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.window_mean = out_mean_reg;
    assign out_ch.window_min  = out_min_reg;
    assign out_ch.window_max  = out_max_reg;
    assign out_ch.ring_full   = out_full_reg;

endmodule

// ----- dv/window_stats_checker.sv -----
// window statistics checker: watches the request channels and config port, predicts and compares
module window_stats_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    bawst_in_if                              in_ch,
    bawst_out_if                             out_ch,
    input  logic                             cfg_we,
    input  logic [bawst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bawst_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               mismatches,
    output int                               outstanding
);
    import bawst_pkg::*;

    localparam int RING     = RING_SLOTS_DEF;
    localparam int MAX_FILL = MAX_BLOCK_DEF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic [SAMPLE_W-1:0] low;
        logic [SAMPLE_W-1:0] high;
        logic                full;
    } window_stats_t;

    logic [BLOCK_LEN_W-1:0]  block_len_reg;
    logic [SLOT_COUNT_W-1:0] slot_count_reg;

    logic [SAMPLE_W-1:0] ring_mean [RING];
    logic [SAMPLE_W-1:0] ring_low [RING];
    logic [SAMPLE_W-1:0] ring_high [RING];
    int unsigned         next_slot;
    int unsigned         filled_slots;

    logic [SUM_W-1:0]    open_sum;
    logic [SAMPLE_W-1:0] open_low;
    logic [SAMPLE_W-1:0] open_high;
    int unsigned         open_fill;

    logic [SAMPLE_W-1:0] last_mean;
    logic [SAMPLE_W-1:0] last_low;
    logic [SAMPLE_W-1:0] last_high;

    window_stats_t pending_stats[$];
    int            fails;

    function automatic void open_block();
        open_sum  = SUM_ZERO;
        open_low  = SAMPLE_ONES;
        open_high = '0;
        open_fill = 0;
    endfunction

    function automatic void clear_window();
        next_slot    = 0;
        filled_slots = 0;
        last_mean    = '0;
        last_low     = '0;
        last_high    = '0;
        open_block();
    endfunction

    function automatic window_stats_t fold_sample(input logic [SAMPLE_W-1:0] x);
        int unsigned         bs;
        int unsigned         sc;
        int unsigned         w;
        logic [63:0]         total;
        logic [63:0]         count;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        window_stats_t       r;
        bs = (block_len_reg == 0) ? 1 : (block_len_reg > MAX_FILL) ? MAX_FILL
            : block_len_reg;
        sc = (slot_count_reg == 0) ? 1 : (slot_count_reg > RING) ? RING : slot_count_reg;
        total = '0;
        count = '0;
        lo    = SAMPLE_ONES;
        hi    = '0;

        open_sum = open_sum + SUM_W'(x);
        open_fill++;
        if (x < open_low)
            open_low = x;
        if (x > open_high)
            open_high = x;

        // block closes into the ring
        if (open_fill >= bs)
        begin
            w = next_slot % RING;
            ring_mean[w] = SAMPLE_W'(open_sum / open_fill);
            ring_low[w]  = open_low;
            ring_high[w] = open_high;
            next_slot    = (w + 1) % sc;
            if (filled_slots < sc)
                filled_slots++;
            open_block();
        end

        for (int i = 0; i < filled_slots && i < RING; i++)
        begin
            total += 64'(ring_mean[i]) * 64'(bs);
            count += 64'(bs);
            if (ring_low[i] < lo)
                lo = ring_low[i];
            if (ring_high[i] > hi)
                hi = ring_high[i];
        end
        if (open_fill > 0)
        begin
            total += 64'(open_sum);
            count += 64'(open_fill);
            if (open_low < lo)
                lo = open_low;
            if (open_high > hi)
                hi = open_high;
        end
        if (count > 0)
        begin
            last_mean = SAMPLE_W'(total / count);
            last_low  = lo;
            last_high = hi;
        end

        r.mean = last_mean;
        r.low  = last_low;
        r.high = last_high;
        r.full = (filled_slots >= sc);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] want,
                                        input logic [SAMPLE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_stats_t want;
        window_stats_t got;
        if (!rst_n)
        begin
            block_len_reg  = BLOCK_LEN_RST;
            slot_count_reg = SLOT_COUNT_RST;
            clear_window();
            pending_stats.delete();
            fails = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.window_mean, out_ch.window_min, out_ch.window_max,
                       out_ch.ring_full};
                if (pending_stats.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %0d %0d %0d %0d",
                             $time, got.mean, got.low, got.high, got.full);
                    fails++;
                end
                else
                begin
                    want = pending_stats.pop_front();
                    check_field("window_mean", want.mean, got.mean);
                    check_field("window_min", want.low, got.low);
                    check_field("window_max", want.high, got.high);
                    check_field("ring_full", SAMPLE_W'(want.full), SAMPLE_W'(got.full));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_BLOCK_LEN)
                begin
                    block_len_reg = cfg_data[BLOCK_LEN_W-1:0];
                    clear_window();
                end
                else if (cfg_index == CFG_SLOT_COUNT)
                begin
                    slot_count_reg = cfg_data[SLOT_COUNT_W-1:0];
                    clear_window();
                end
            end
            if (in_ch.valid && in_ch.ready)
                pending_stats.push_back(fold_sample(in_ch.sample));
        end
        outstanding <= pending_stats.size();
        mismatches  <= fails;
    end

endmodule

// ----- dv/tb_top.sv -----
// testbench top: clock, reset, sample and config stimulus, output stalls and verdict
module tb_top;
    import bawst_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int SAMPLE_TARGET = 1000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;

    bit                    steady_in;
    bit                    steady_out;
    int                    samples_sent;
    logic [SAMPLE_W-1:0]   center;
    logic [SAMPLE_W-1:0]   spread;
    logic [CFG_DATA_W-1:0] cur_block;
    logic [CFG_DATA_W-1:0] cur_slots;

    bawst_in_if  in_if ();
    bawst_out_if out_if ();

    block_averaged_window_stats DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    window_stats_checker stats_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_if),
        .out_ch      (out_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int pause_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        if (roll < 97)
            return $urandom_range(5, 30);
        return $urandom_range(60, 250);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = steady_in ? 0 : pause_len();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= value;
        do
            @(posedge clk);
        while (!in_if.ready);
        samples_sent++;
    endtask

    task automatic run_samples(input int count);
        int                  roll;
        logic [SAMPLE_W-1:0] value;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                center = SAMPLE_W'($urandom_range(0, 65535));
            if (roll >= 95)
                value = SAMPLE_ONES;
            else if (roll >= 92)
                value = '0;
            else
                value = center ^ (SAMPLE_W'($urandom) & spread);
            send_sample(value);
        end
    endtask

    // wait for every request to come back and the block to go quiet
    task automatic quiesce();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_BLOCK_LEN)
            cur_block = data;
        else if (idx == CFG_SLOT_COUNT)
            cur_slots = data & 8'h7F;
        @(posedge clk);
    endtask

    task automatic cfg_close();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pick_spread();
        case ($urandom_range(0, 4))
            0: spread = 16'h0000;
            1: spread = 16'h000F;
            2: spread = 16'h00FF;
            3: spread = 16'h0FFF;
            default: spread = 16'hFFFF;
        endcase
        center = SAMPLE_W'($urandom_range(0, 65535));
    endtask

    initial
    begin
        out_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_if.ready <= 1'b1;
        forever
        begin
            int hold;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            hold = steady_out ? 0 : pause_len();
            if (hold > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
                out_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int                    len;
        int                    eb;
        int                    es;
        logic [CFG_DATA_W-1:0] block_raw;
        logic [CFG_DATA_W-1:0] slot_raw;
        int                    roll;
        logic [SAMPLE_W-1:0]   opening [8];
        opening = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE,
                    16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF};

        rst_n        <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.sample <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_BLOCK_LEN;
        cfg_data     <= '0;
        steady_in    = 1'b0;
        steady_out   = 1'b0;
        samples_sent = 0;
        cur_block    = BLOCK_LEN_RST;
        cur_slots    = CFG_DATA_W'(SLOT_COUNT_RST);
        center       = '0;
        spread       = 16'hFFFF;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, field extremes
        foreach (opening[i])
            send_sample(opening[i]);

        // writes to unused indexes keep the window
        quiesce();
        cfg_write(CFG_SPARE_A, 8'h03);
        cfg_write(CFG_SPARE_B, 8'hFF);
        cfg_close();
        send_sample(16'd100);
        send_sample(16'hFFFF);
        send_sample(16'h0000);

        // zero block length and zero slot count act as one
        quiesce();
        cfg_write(CFG_BLOCK_LEN, 8'h00);
        cfg_write(CFG_SLOT_COUNT, 8'h00);
        cfg_close();
        send_sample(16'd7);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'd12345);

        // oversize values clamp to the largest block and ring
        quiesce();
        cfg_write(CFG_BLOCK_LEN, 8'hFF);
        cfg_write(CFG_SLOT_COUNT, 8'hFF);
        cfg_close();
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h1234);
        send_sample(16'hFFFF);

        quiesce();
        cfg_write(CFG_BLOCK_LEN, 8'd2);
        cfg_write(CFG_SLOT_COUNT, 8'd3);
        cfg_close();
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h4000);
        send_sample(16'hC000);

        // largest block into a single slot, through a wrap
        quiesce();
        cfg_write(CFG_SLOT_COUNT, 8'd1);
        cfg_write(CFG_BLOCK_LEN, 8'd128);
        cfg_close();
        pick_spread();
        spread = 16'hFFFF;
        run_samples(260);

        // one sample per slot over the full ring
        quiesce();
        cfg_write(CFG_BLOCK_LEN, 8'd1);
        cfg_write(CFG_SLOT_COUNT, 8'd64);
        cfg_close();
        pick_spread();
        run_samples(140);

        while (samples_sent < SAMPLE_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                block_raw = CFG_DATA_W'($urandom_range(1, 4));
            else if (roll < 70)
                block_raw = CFG_DATA_W'($urandom_range(5, 16));
            else if (roll < 80)
                block_raw = 8'd0;
            else if (roll < 88)
                block_raw = CFG_DATA_W'($urandom_range(17, 64));
            else if (roll < 94)
                block_raw = 8'd128;
            else
                block_raw = CFG_DATA_W'($urandom_range(129, 255));

            roll = $urandom_range(0, 99);
            if (roll < 50)
                slot_raw = CFG_DATA_W'($urandom_range(1, 8));
            else if (roll < 70)
                slot_raw = CFG_DATA_W'($urandom_range(9, 20));
            else if (roll < 78)
                slot_raw = 8'd0;
            else if (roll < 86)
                slot_raw = CFG_DATA_W'($urandom_range(21, 63));
            else if (roll < 93)
                slot_raw = 8'd64;
            else
                slot_raw = CFG_DATA_W'($urandom_range(65, 127));
            slot_raw[7] = 1'($urandom_range(0, 1));

            quiesce();
            case ($urandom_range(0, 5))
                0: cfg_write(CFG_BLOCK_LEN, block_raw);
                1: cfg_write(CFG_SLOT_COUNT, slot_raw);
                2:
                begin
                    cfg_write(CFG_SLOT_COUNT, slot_raw);
                    cfg_write(CFG_BLOCK_LEN, block_raw);
                end
                default:
                begin
                    cfg_write(CFG_BLOCK_LEN, block_raw);
                    cfg_write(CFG_SLOT_COUNT, slot_raw);
                end
            endcase
            if ($urandom_range(0, 4) == 0)
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          CFG_DATA_W'($urandom_range(0, 255)));
            cfg_close();

            steady_in  = ($urandom_range(0, 3) == 0);
            steady_out = ($urandom_range(0, 3) == 0);
            pick_spread();

            eb = (cur_block == 0) ? 1 : (cur_block > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : cur_block;
            es = (cur_slots == 0) ? 1 : (cur_slots > RING_SLOTS_DEF) ? RING_SLOTS_DEF
                : cur_slots;
            len = eb * es * 2 + $urandom_range(1, 12);
            if (len > 150)
                len = $urandom_range(60, 150);
            run_samples(len);
        end

        steady_in  = 1'b0;
        steady_out = 1'b0;
        quiesce();
        if (mismatches == 0)
            $display("block_averaged_window_stats verification clean");
        else
            $display("block_averaged_window_stats verification failed");
        $finish;
    end

    initial
    begin
        #48_000_000;
        $display("block_averaged_window_stats verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bawst_pkg.sv
hw/rtl/bawst_if.sv
hw/rtl/bawst_ram.sv
hw/rtl/bawst_div.sv
hw/rtl/block_averaged_window_stats.sv
dv/window_stats_checker.sv
dv/tb_top.sv
